FILE: hdl/lzfg_pkg.sv
package lzfg_pkg;

    localparam int HIST_AW    = 12;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int BYTE_W     = 8;
    localparam int SLOT_W     = 4;
    localparam int PROD_W     = HIST_AW + 1;
    localparam int NIB_W      = 4;

    // slots of one flag group
    localparam logic [SLOT_W-1:0] GROUP_SLOTS = SLOT_W'(8);
    // produced count saturates at the history size
    localparam logic [PROD_W-1:0] PROD_FULL   = PROD_W'(HIST_DEPTH);

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [HIST_AW-1:0] hist_addr_t;
    typedef logic [PROD_W-1:0]  prod_t;
    typedef logic [SLOT_W-1:0]  slot_t;

endpackage

FILE: hdl/lzfg_ram.sv
module lzfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/lz77_flag_group_decoder_core.sv
// LZSS decoder with a 4096-byte history and flag groups of eight slots.
// Input: one compressed byte per request on s_axis; s_axis_tuser marks the
// first byte of a stream, which is a flag byte. Output: one decoded byte per
// request on m_axis; m_axis_tlast closes the results of one input byte and
// m_axis_tuser flags a bad match distance (data 0, tlast 1, nothing copied).
// Flag bytes and match high bytes give no result.
// A literal shows on m_axis the cycle after acceptance;
// literals stream at one per cycle while m_axis_tready stays high.
// A match low byte copies MIN_MATCH..MIN_MATCH+15 bytes, each one through
// ST_COPY_RD and ST_COPY_WR: a read is issued, the registered data
// comes back, the byte is emitted and written at the write pointer, and the
// next read sees that write, so overlapping copies are exact.
// s_axis_tready is low during a copy and while a result waits unaccepted.
// A stall on m_axis holds the pending result and freezes the copy.
// Reset clears pointer, counters and flag state (as if an all-zero flag byte
// had arrived); the history memory is not cleared and needs no sweep.
module lz77_flag_group_decoder_core #(
    parameter int MIN_MATCH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte
    input  logic       s_axis_tuser,   // start_of_stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tlast,   // last
    output logic       m_axis_tuser    // bad_distance
);

    localparam int LEN_W = $clog2((1 << lzfg_pkg::NIB_W) + MIN_MATCH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR
    } state_t;

    state_t               state_reg, state_next;
    lzfg_pkg::hist_addr_t wp_reg, wp_next;
    lzfg_pkg::prod_t      prod_reg, prod_next;
    lzfg_pkg::byte_t      flag_reg, flag_next;
    lzfg_pkg::slot_t      slot_reg, slot_next;
    logic                 pend_reg, pend_next;
    lzfg_pkg::byte_t      dhi_reg, dhi_next;
    lzfg_pkg::hist_addr_t dist_reg, dist_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic                 ovalid_reg, ovalid_next;
    lzfg_pkg::byte_t      odata_reg, odata_next;
    logic                 olast_reg, olast_next;
    logic                 obad_reg, obad_next;

    logic                 out_free;
    logic                 in_acc;
    logic                 ram_we;
    lzfg_pkg::byte_t      ram_wdata;
    lzfg_pkg::byte_t      ram_rdata;
    lzfg_pkg::hist_addr_t rd_addr;
    lzfg_pkg::hist_addr_t dist_in;
    logic                 slot_bit;

    assign out_free      = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign rd_addr       = wp_reg - dist_reg;
    assign dist_in       = {dhi_reg, s_axis_tdata[7:4]};
    assign slot_bit      = flag_reg[slot_reg[2:0]];

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = obad_reg;

    lzfg_ram #(
        .WIDTH(lzfg_pkg::BYTE_W),
        .DEPTH(lzfg_pkg::HIST_DEPTH)
    ) u_hist (
        .aclk   (aclk),
        .we     (ram_we),
        .wr_addr(wp_reg),
        .wr_data(ram_wdata),
        .rd_addr(rd_addr),
        .rd_data(ram_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        prod_next   = prod_reg;
        flag_next   = flag_reg;
        slot_next   = slot_reg;
        pend_next   = pend_reg;
        dhi_next    = dhi_reg;
        dist_next   = dist_reg;
        rem_next    = rem_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        obad_next   = obad_reg;
        ram_we      = 1'b0;
        ram_wdata   = s_axis_tdata;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser) begin
                        flag_next = s_axis_tdata;
                        slot_next = '0;
                        pend_next = 1'b0;
                        prod_next = '0;
                    end else if (slot_reg >= lzfg_pkg::GROUP_SLOTS) begin
                        flag_next = s_axis_tdata;
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                        if (!slot_bit) begin
                            ram_we      = 1'b1;
                            wp_next     = wp_reg + 1'b1;
                            if (prod_reg < lzfg_pkg::PROD_FULL) begin
                                prod_next = prod_reg + 1'b1;
                            end
                            ovalid_next = 1'b1;
                            odata_next  = s_axis_tdata;
                            olast_next  = 1'b1;
                            obad_next   = 1'b0;
                        end else if (!pend_reg) begin
                            dhi_next  = s_axis_tdata;
                            pend_next = 1'b1;
                        end else begin
                            pend_next = 1'b0;
                            if (dist_in == '0 ||
                                lzfg_pkg::PROD_W'(dist_in) > prod_reg) begin
                                ovalid_next = 1'b1;
                                odata_next  = '0;
                                olast_next  = 1'b1;
                                obad_next   = 1'b1;
                            end else begin
                                dist_next  = dist_in;
                                rem_next   = LEN_W'(s_axis_tdata[3:0]) + LEN_W'(MIN_MATCH);
                                state_next = ST_COPY_RD;
                            end
                        end
                    end
                end
            end
            // memory samples rd_addr at the end of this cycle
            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata;
                    wp_next     = wp_reg + 1'b1;
                    if (prod_reg < lzfg_pkg::PROD_FULL) begin
                        prod_next = prod_reg + 1'b1;
                    end
                    ovalid_next = 1'b1;
                    odata_next  = ram_rdata;
                    olast_next  = (rem_reg == LEN_W'(1));
                    obad_next   = 1'b0;
                    rem_next    = rem_reg - 1'b1;
                    state_next  = (rem_reg == LEN_W'(1)) ? ST_IDLE : ST_COPY_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            prod_reg   <= '0;
            flag_reg   <= '0;
            slot_reg   <= '0;
            pend_reg   <= 1'b0;
            dhi_reg    <= '0;
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            prod_reg   <= prod_next;
            flag_reg   <= flag_next;
            slot_reg   <= slot_next;
            pend_reg   <= pend_next;
            dhi_reg    <= dhi_next;
            rem_reg    <= rem_next;
            ovalid_reg <= ovalid_next;
        end
        dist_reg  <= dist_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        obad_reg  <= obad_next;
    end

    // a bad distance result is always the only and final one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("bad distance result without tlast or with data");

    // no copy runs with an empty length counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> rem_reg != '0)
        else $error("copy active with zero remaining length");

    // produced count never passes the history size
    assert property (@(posedge aclk) disable iff (!aresetn)
        prod_reg <= lzfg_pkg::PROD_FULL)
        else $error("produced count overflow");

    // every history write advances the write pointer by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> wp_reg == $past(wp_reg) + 1'b1)
        else $error("write pointer out of step with history writes");

    // copy output is never entered straight from idle, only after a read cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_COPY_WR |-> $past(state_reg) != ST_IDLE)
        else $error("copy output without a read cycle");

endmodule
